// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the date parser modules.
// Each macro checks on the rising edge of i_clk and is quiet while i_rst_n
// is low. The module that uses them must have both signals in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define HFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define HFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/hfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_pkg
// Types, character constants and the month table of the fixdate parser.
// ----------------------------------------------------------------------------
package hfp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int MONTH_COUNT = 12;

    localparam logic [4:0] POS_LAST = 5'd28;
    localparam logic [4:0] POS_MAX  = 5'd31;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [6:0]  DAY_MAX    = 7'd31;
    localparam logic [6:0]  HOUR_MAX   = 7'd23;
    localparam logic [6:0]  MINUTE_MAX = 7'd59;
    localparam logic [6:0]  SECOND_MAX = 7'd60;
    localparam logic [13:0] YEAR_MIN   = 14'd1970;
    localparam logic [13:0] YEAR_BASE  = 14'd1900;

    localparam logic [3:0] MONTH_NONE = 4'd12;

    localparam logic [23:0] MONTH_CODES [MONTH_COUNT] = '{
        24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
        24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
    };

    // What the back end does with one byte.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ERR,
        OP_DAY,
        OP_MONTH,
        OP_YEAR,
        OP_HOUR,
        OP_MINUTE,
        OP_SECOND
    } t_hfp_op;

    typedef struct packed {
        logic [7:0] data;
        t_hfp_op    op;
        logic       last;
        logic       at_end;
    } t_hfp_entry;

    // Declared high field first so that date_valid lands in bit 0.
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [12:0] year_since_1900;
        logic [3:0]  month_index;
        logic [4:0]  day;
        logic        date_valid;
    } t_hfp_result;

    // Returns the month index for three month letters, MONTH_NONE if unknown.
    function automatic logic [3:0] month_lookup(input logic [23:0] letters);
        logic [3:0] idx;
        idx = MONTH_NONE;
        for (int m = MONTH_COUNT - 1; m >= 0; m--) begin
            if (letters == MONTH_CODES[m]) begin
                idx = 4'(m);
            end
        end
        return idx;
    endfunction

endpackage

// ----- hw/rtl/http_fixdate_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_fixdate_parser
// Parses an IMF-fixdate header, one byte per transaction, into date fields.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                              Closes with
//  s_axis    in   tdata[7:0] header_char, tlast last   one per byte
//  m_axis    out  tdata[39:0] packed date result       one per header
//
// One byte is accepted every clock cycle while the queue has room; the
// front end classifies it by position in the same cycle and a four-entry
// queue feeds the back end. The final byte is first written into the
// queue; when the back end pops it, it loads the result into the output
// register, which presents it on m_axis.
// Synchronous active-low reset clears the position counter, the queue, the
// accumulators and the output valid flag.
// A stalled output stops only the final byte of the next header; bytes ahead
// of it keep draining into the accumulators, and input stalls only when the
// queue fills.
// ----------------------------------------------------------------------------
module http_fixdate_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] header_char
    input  logic        s_axis_tlast,   // marks the final byte of the header
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [0] date_valid, [5:1] day,
                                        // [9:6] month_index,
                                        // [22:10] year_since_1900,
                                        // [27:23] hour, [33:28] minute,
                                        // [39:34] second
);
    import hfp_pkg::*;

    logic        push;
    logic        queue_ready;
    logic        queue_valid;
    logic        pop;
    t_hfp_entry  front_entry;
    t_hfp_entry  queue_entry;
    t_hfp_result result;

    // Front end: position counter and per-byte classification.
    hfp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_char        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_queue_ready (queue_ready),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    // Decoupling queue so either side can stall on its own.
    hfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_entry (queue_entry),
        .i_pop   (pop)
    );

    // Back end: accumulators, month decode, range checks and output register.
    hfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_entry     (queue_entry),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = result;

endmodule

// ----- hw/rtl/hfp_front.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// hfp_front
// Counts header positions and classifies each byte into a back-end operation.
// ----------------------------------------------------------------------------
module hfp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_char,
    input  logic               i_last,
    input  logic               i_queue_ready,
    output logic               o_ready,
    output logic               o_push,
    output hfp_pkg::t_hfp_entry o_entry
);
    import hfp_pkg::*;

    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic       accept;
    logic       is_digit;
    t_hfp_op    op;

    assign o_ready  = i_queue_ready;
    assign accept   = i_valid && i_queue_ready;
    assign o_push   = accept;
    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);

    always_comb begin
        unique case (r_pos) inside
            5'd0, 5'd1, 5'd2: op = OP_NOP;
            5'd3:  op = (i_char == CH_COMMA) ? OP_NOP : OP_ERR;
            5'd4, 5'd7, 5'd11, 5'd16, 5'd25:
                   op = (i_char == CH_SPACE) ? OP_NOP : OP_ERR;
            5'd19, 5'd22:
                   op = (i_char == CH_COLON) ? OP_NOP : OP_ERR;
            5'd26: op = (i_char == CH_G) ? OP_NOP : OP_ERR;
            5'd27: op = (i_char == CH_M) ? OP_NOP : OP_ERR;
            5'd28: op = (i_char == CH_T) ? OP_NOP : OP_ERR;
            5'd5, 5'd6:       op = is_digit ? OP_DAY : OP_ERR;
            [5'd8:5'd10]:     op = OP_MONTH;
            [5'd12:5'd15]:    op = is_digit ? OP_YEAR : OP_ERR;
            5'd17, 5'd18:     op = is_digit ? OP_HOUR : OP_ERR;
            5'd20, 5'd21:     op = is_digit ? OP_MINUTE : OP_ERR;
            5'd23, 5'd24:     op = is_digit ? OP_SECOND : OP_ERR;
            default:          op = OP_ERR;
        endcase
    end

    always_comb begin
        o_entry.data   = i_char;
        o_entry.op     = op;
        o_entry.last   = i_last;
        o_entry.at_end = (r_pos == POS_LAST);
    end

    // The counter saturates so an overlong header keeps landing in the error arm.
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_last) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    `HFP_ASSERT_NEXT(a_pos_restart, accept && i_last, r_pos == 5'd0,
        "position did not restart after the final byte")
    `HFP_ASSERT_NEXT(a_pos_hold, !accept, $stable(r_pos),
        "position moved without a transaction")

endmodule

// ----- hw/rtl/hfp_queue.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// hfp_queue
// Short FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module hfp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hfp_pkg::t_hfp_entry i_entry,
    output logic                o_ready,
    output logic                o_valid,
    output hfp_pkg::t_hfp_entry o_entry,
    input  logic                i_pop
);
    import hfp_pkg::*;

    t_hfp_entry            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic [QUEUE_CW-1:0]   n_count;

    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

    `HFP_ASSERT(a_no_overflow, !(i_push && !o_ready),
        "push into a full queue")
    `HFP_ASSERT(a_no_underflow, !(i_pop && !o_valid),
        "pop from an empty queue")

endmodule

// ----- hw/rtl/hfp_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// hfp_back
// Accumulates the numeric fields and month letters and builds the result.
// ----------------------------------------------------------------------------
module hfp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  hfp_pkg::t_hfp_entry  i_entry,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output hfp_pkg::t_hfp_result o_result,
    input  logic                 i_out_ready
);
    import hfp_pkg::*;

    logic        r_err;
    logic [6:0]  r_day;
    logic [23:0] r_month;
    logic [13:0] r_year;
    logic [6:0]  r_hour;
    logic [6:0]  r_minute;
    logic [6:0]  r_second;

    logic        r_out_valid;
    t_hfp_result r_out;

    logic        out_free;
    logic        pop;
    logic [3:0]  digit;
    logic        err_all;
    logic        ok;
    logic [3:0]  month_idx;
    logic [13:0] year_off;
    t_hfp_result result;

    // acc * 10 + digit within the accumulator width.
    function automatic logic [6:0] mac7(input logic [6:0] acc, input logic [3:0] d);
        return {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'b000, d};
    endfunction

    function automatic logic [13:0] mac14(input logic [13:0] acc, input logic [3:0] d);
        return {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, d};
    endfunction

    assign out_free = !r_out_valid || i_out_ready;
    assign pop      = i_valid && (!i_entry.last || out_free);
    assign o_pop    = pop;
    assign digit    = i_entry.data[3:0];

    // On the closing byte no accumulator changes, so the result reads the
    // registers; only the error flag needs this byte's contribution.
    assign err_all   = r_err || (i_entry.op == OP_ERR);
    assign month_idx = month_lookup(r_month);
    assign year_off  = r_year - YEAR_BASE;

    assign ok = i_entry.at_end && !err_all && (month_idx != MONTH_NONE)
             && (r_day != 7'd0) && (r_day <= DAY_MAX) && (r_hour <= HOUR_MAX)
             && (r_minute <= MINUTE_MAX) && (r_second <= SECOND_MAX)
             && (r_year >= YEAR_MIN);

    always_comb begin
        result = '0;
        if (ok) begin
            result.date_valid      = 1'b1;
            result.day             = r_day[4:0];
            result.month_index     = month_idx;
            result.year_since_1900 = year_off[12:0];
            result.hour            = r_hour[4:0];
            result.minute          = r_minute[5:0];
            result.second          = r_second[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err    <= 1'b0;
            r_day    <= '0;
            r_month  <= '0;
            r_year   <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
        end else if (pop) begin
            if (i_entry.last) begin
                r_err    <= 1'b0;
                r_day    <= '0;
                r_month  <= '0;
                r_year   <= '0;
                r_hour   <= '0;
                r_minute <= '0;
                r_second <= '0;
            end else begin
                unique case (i_entry.op)
                    OP_NOP:    ;
                    OP_ERR:    r_err    <= 1'b1;
                    OP_DAY:    r_day    <= mac7(r_day, digit);
                    OP_MONTH:  r_month  <= {r_month[15:0], i_entry.data};
                    OP_YEAR:   r_year   <= mac14(r_year, digit);
                    OP_HOUR:   r_hour   <= mac7(r_hour, digit);
                    OP_MINUTE: r_minute <= mac7(r_minute, digit);
                    OP_SECOND: r_second <= mac7(r_second, digit);
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_entry.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_entry.last) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `HFP_ASSERT_NEXT(a_result_loaded, pop && i_entry.last, r_out_valid,
        "final byte consumed but no result presented")
    `HFP_ASSERT(a_invalid_is_zero,
        !(r_out_valid && !r_out.date_valid) || (r_out == t_hfp_result'(0)),
        "invalid result carries nonzero fields")

endmodule

// ----- verif/hfp_date_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_date_checker
// Watches both streams of the fixdate parser. It predicts the date result of
// each header from the accepted bytes and compares it with what comes out.
// ----------------------------------------------------------------------------
module hfp_date_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hdr_tvalid,
    input  logic        i_hdr_tready,
    input  logic [7:0]  i_hdr_tdata,    // [7:0] header_char
    input  logic        i_hdr_tlast,    // final byte of the header
    input  logic        i_date_tvalid,
    input  logic        i_date_tready,
    input  logic [39:0] i_date_tdata,   // [0] date_valid, [5:1] day,
                                        // [9:6] month_index,
                                        // [22:10] year_since_1900,
                                        // [27:23] hour, [33:28] minute,
                                        // [39:34] second
    output int          o_error_count,
    output int          o_dates_due,
    output int          o_dates_seen,
    output int          o_dates_valid
);

    import hfp_pkg::*;

    // Parser state as predicted from the accepted bytes.
    logic [4:0]  hdr_pos;
    logic        hdr_bad;
    logic [6:0]  day_acc;
    logic [6:0]  hour_acc;
    logic [6:0]  minute_acc;
    logic [6:0]  second_acc;
    logic [13:0] year_acc;
    logic [23:0] month_chars;

    t_hfp_result dates_due_q[$];
    int          error_count;
    int          dates_seen;
    int          dates_valid;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Accumulator times ten plus the new digit, wide enough for the year.
    function automatic logic [13:0] decimal_push(input logic [13:0] acc, input logic [7:0] c);
        return 14'(acc * 10 + (c - CH_ZERO));
    endfunction

    task automatic clear_header_state();
        hdr_pos     = '0;
        hdr_bad     = 1'b0;
        day_acc     = '0;
        hour_acc    = '0;
        minute_acc  = '0;
        second_acc  = '0;
        year_acc    = '0;
        month_chars = '0;
    endtask

    task automatic take_header_byte(input logic [7:0] c, input logic last);
        logic [4:0]  at;
        logic [3:0]  month;
        logic        ok;
        t_hfp_result want;
        at = hdr_pos;
        case (at)
            5'd0, 5'd1, 5'd2: ;
            5'd3: if (c != CH_COMMA) hdr_bad = 1'b1;
            5'd4, 5'd7, 5'd11, 5'd16, 5'd25: if (c != CH_SPACE) hdr_bad = 1'b1;
            5'd19, 5'd22: if (c != CH_COLON) hdr_bad = 1'b1;
            5'd26: if (c != CH_G) hdr_bad = 1'b1;
            5'd27: if (c != CH_M) hdr_bad = 1'b1;
            5'd28: if (c != CH_T) hdr_bad = 1'b1;
            5'd5, 5'd6: begin
                if (is_digit(c)) day_acc = 7'(decimal_push({7'd0, day_acc}, c));
                else hdr_bad = 1'b1;
            end
            5'd8, 5'd9, 5'd10: month_chars = {month_chars[15:0], c};
            5'd12, 5'd13, 5'd14, 5'd15: begin
                if (is_digit(c)) year_acc = decimal_push(year_acc, c);
                else hdr_bad = 1'b1;
            end
            5'd17, 5'd18: begin
                if (is_digit(c)) hour_acc = 7'(decimal_push({7'd0, hour_acc}, c));
                else hdr_bad = 1'b1;
            end
            5'd20, 5'd21: begin
                if (is_digit(c)) minute_acc = 7'(decimal_push({7'd0, minute_acc}, c));
                else hdr_bad = 1'b1;
            end
            5'd23, 5'd24: begin
                if (is_digit(c)) second_acc = 7'(decimal_push({7'd0, second_acc}, c));
                else hdr_bad = 1'b1;
            end
            default: hdr_bad = 1'b1;
        endcase
        if (hdr_pos != POS_MAX) hdr_pos = hdr_pos + 5'd1;

        if (last) begin
            month = MONTH_NONE;
            for (int m = 0; m < MONTH_COUNT; m++) begin
                if (month == MONTH_NONE && month_chars == MONTH_CODES[m]) month = 4'(m);
            end
            ok = (at == POS_LAST) && !hdr_bad && (month != MONTH_NONE) &&
                 (day_acc >= 7'd1) && (day_acc <= DAY_MAX) && (hour_acc <= HOUR_MAX) &&
                 (minute_acc <= MINUTE_MAX) && (second_acc <= SECOND_MAX) &&
                 (year_acc >= YEAR_MIN);
            want = '0;
            if (ok) begin
                want.date_valid      = 1'b1;
                want.day             = 5'(day_acc);
                want.month_index     = month;
                want.year_since_1900 = 13'(year_acc - YEAR_BASE);
                want.hour            = 5'(hour_acc);
                want.minute          = 6'(minute_acc);
                want.second          = 6'(second_acc);
            end
            dates_due_q.push_back(want);
            clear_header_state();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("hfp_date_checker: %s mismatch at %0t ns: got %0d, expected %0d",
                 what, $time, got, want);
        error_count++;
    endtask

    task automatic compare_date(input t_hfp_result got, input t_hfp_result want);
        if (got.date_valid !== want.date_valid)
            report_mismatch("date_valid", got.date_valid, want.date_valid);
        if (got.day !== want.day) report_mismatch("day", got.day, want.day);
        if (got.month_index !== want.month_index)
            report_mismatch("month_index", got.month_index, want.month_index);
        if (got.year_since_1900 !== want.year_since_1900)
            report_mismatch("year_since_1900", got.year_since_1900, want.year_since_1900);
        if (got.hour !== want.hour) report_mismatch("hour", got.hour, want.hour);
        if (got.minute !== want.minute) report_mismatch("minute", got.minute, want.minute);
        if (got.second !== want.second) report_mismatch("second", got.second, want.second);
    endtask

    always @(posedge i_clk) begin
        t_hfp_result oldest;
        if (!i_rst_n) begin
            clear_header_state();
            dates_due_q.delete();
        end else begin
            if (i_hdr_tvalid && i_hdr_tready) take_header_byte(i_hdr_tdata, i_hdr_tlast);
            if (i_date_tvalid && i_date_tready) begin
                if (dates_due_q.size() == 0) begin
                    report_mismatch("date result with no header pending", 1, 0);
                end else begin
                    oldest = dates_due_q.pop_front();
                    compare_date(t_hfp_result'(i_date_tdata), oldest);
                    dates_seen++;
                    if (oldest.date_valid) dates_valid++;
                end
            end
        end
        o_error_count <= error_count;
        o_dates_due   <= dates_due_q.size();
        o_dates_seen  <= dates_seen;
        o_dates_valid <= dates_valid;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams IMF-fixdate headers into the parser, byte by byte, under changing
// input gaps and output stalls; the date checker beside the parser predicts
// and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    import hfp_pkg::*;

    localparam int CLK_HALF_NS        = 10;
    localparam int RESET_CYCLES       = 3;
    // Floor on random header bytes, and a floor on random headers so that
    // every idling phase gets its turn.
    localparam int RANDOM_BYTES       = 160;
    localparam int MIN_RANDOM_HEADERS = 8;
    // Settling margin after the last pending date has come back.
    localparam int DRAIN_CYCLES       = 8;
    localparam int LONG_HOLD_CYCLES   = 400;
    // About 1200 bytes in all; even at the worst idling the whole run stays far
    // below this limit.
    localparam int CYCLE_LIMIT        = 60000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] header_char
    logic        s_axis_tlast = 1'b0;   // final byte of the header
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [0] date_valid, [5:1] day,
                                        // [9:6] month_index,
                                        // [22:10] year_since_1900,
                                        // [27:23] hour, [33:28] minute,
                                        // [39:34] second

    int error_count;
    int dates_due;
    int dates_seen;
    int dates_valid;

    // Idling percentages; written only at a falling edge.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // The long output hold-off: the stimulus toggles hold_trigger, the
    // receiver process notices the change and counts the stretch itself.
    logic hold_trigger = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    int cycle_count  = 0;
    int bytes_sent   = 0;
    int headers_sent = 0;

    // Bytes of the header being built, first byte at index 0.
    logic [7:0] hdr_bytes[$];

    http_fixdate_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hfp_date_checker u_date_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hdr_tvalid  (s_axis_tvalid),
        .i_hdr_tready  (s_axis_tready),
        .i_hdr_tdata   (s_axis_tdata),
        .i_hdr_tlast   (s_axis_tlast),
        .i_date_tvalid (m_axis_tvalid),
        .i_date_tready (m_axis_tready),
        .i_date_tdata  (m_axis_tdata),
        .o_error_count (error_count),
        .o_dates_due   (dates_due),
        .o_dates_seen  (dates_seen),
        .o_dates_valid (dates_valid)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Receiver: random stalls at the current rate, or a long hold-off when
    // the stimulus asks for one.
    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen     <= hold_trigger;
            hold_left     <= LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Offers one byte, after random idle cycles, and returns at the rising
    // edge that accepted it. The handshake is sampled at the falling edge,
    // where every signal has settled since the last rising edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        bytes_sent++;
    endtask

    task automatic send_header();
        foreach (hdr_bytes[i]) send_byte(hdr_bytes[i], i == hdr_bytes.size() - 1);
        headers_sent++;
    endtask

    // Lowers tvalid, then waits until every pending date has come back and
    // the parser has had time to settle. Returns at a rising edge.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (dates_due != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic start_phase(input int send_pct, input int recv_pct);
        wait_drained();
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        @(posedge i_clk);
    endtask

    task automatic hold_receiver();
        @(negedge i_clk);
        hold_trigger = ~hold_trigger;
        @(posedge i_clk);
    endtask

    task automatic push_decimal(input int value, input int digits);
        int scale;
        scale = 1;
        repeat (digits - 1) scale *= 10;
        repeat (digits) begin
            hdr_bytes.push_back(8'(CH_ZERO + (value / scale) % 10));
            scale /= 10;
        end
    endtask

    // Builds "Www, DD Mmm YYYY hh:mm:ss GMT"; the weekday bytes are random
    // over the whole byte range since the parser never looks at them.
    task automatic compose_fixdate(input int day, input int month, input int year,
                                   input int hour, input int minute, input int second);
        hdr_bytes.delete();
        repeat (3) hdr_bytes.push_back(8'($urandom_range(255)));
        hdr_bytes.push_back(CH_COMMA);
        hdr_bytes.push_back(CH_SPACE);
        push_decimal(day, 2);
        hdr_bytes.push_back(CH_SPACE);
        hdr_bytes.push_back(MONTH_CODES[month][23:16]);
        hdr_bytes.push_back(MONTH_CODES[month][15:8]);
        hdr_bytes.push_back(MONTH_CODES[month][7:0]);
        hdr_bytes.push_back(CH_SPACE);
        push_decimal(year, 4);
        hdr_bytes.push_back(CH_SPACE);
        push_decimal(hour, 2);
        hdr_bytes.push_back(CH_COLON);
        push_decimal(minute, 2);
        hdr_bytes.push_back(CH_COLON);
        push_decimal(second, 2);
        hdr_bytes.push_back(CH_SPACE);
        hdr_bytes.push_back(CH_G);
        hdr_bytes.push_back(CH_M);
        hdr_bytes.push_back(CH_T);
    endtask

    // Mostly a legal value; now and then anything the digits can spell.
    function automatic int pick_field(input int lo, input int hi, input int widest);
        if ($urandom_range(15) == 0) return $urandom_range(widest);
        return $urandom_range(hi, lo);
    endfunction

    task automatic compose_random_fixdate();
        compose_fixdate(pick_field(1, 31, 99), $urandom_range(11), pick_field(1970, 9999, 9999),
                        pick_field(0, 23, 99), pick_field(0, 59, 99), pick_field(0, 60, 99));
    endtask

    initial begin
        int m;
        int kind;
        int cut;
        int rand_headers;
        int first_random_byte;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed headers. A well-known valid date first.
        compose_fixdate(6, 10, 1994, 8, 49, 37);
        send_header();

        // Every month; January carries the low extremes, December the high.
        for (m = 0; m < MONTH_COUNT; m++) begin
            compose_fixdate((m == 0) ? 1 : (m == 11) ? 31 : 2 * m + 5, m,
                            (m == 0) ? 1970 : (m == 11) ? 9999 : 1970 + 37 * m,
                            (m == 11) ? 23 : m, (m == 11) ? 59 : 5 * m,
                            (m == 11) ? 60 : 4 * m);
            send_header();
        end

        // Each range check just past its limit.
        compose_fixdate(0, 3, 2000, 12, 0, 0);   send_header();
        compose_fixdate(32, 3, 2000, 12, 0, 0);  send_header();
        compose_fixdate(15, 3, 2000, 24, 0, 0);  send_header();
        compose_fixdate(15, 3, 2000, 12, 60, 0); send_header();
        compose_fixdate(15, 3, 2000, 12, 0, 61); send_header();
        compose_fixdate(15, 3, 1969, 12, 0, 0);  send_header();

        // Non-digits just above nine and just below zero in numeric fields.
        compose_fixdate(15, 5, 2020, 10, 20, 30);
        hdr_bytes[6] = CH_COLON;
        send_header();
        compose_fixdate(15, 5, 2020, 10, 20, 30);
        hdr_bytes[23] = 8'(CH_ZERO - 8'd1);
        send_header();

        // A space where a colon belongs, and a broken zone literal.
        compose_fixdate(15, 5, 2020, 10, 20, 30);
        hdr_bytes[19] = CH_SPACE;
        send_header();
        compose_fixdate(15, 5, 2020, 10, 20, 30);
        hdr_bytes[28] = "X";
        send_header();

        // Month names are case-sensitive.
        compose_fixdate(15, 10, 2020, 10, 20, 30);
        hdr_bytes[8] = "n";
        send_header();

        // Wrong lengths: a lone byte, one byte short, one over, far over
        // so that the position counter saturates.
        hdr_bytes.delete();
        hdr_bytes.push_back("S");
        send_header();
        compose_fixdate(15, 5, 2020, 10, 20, 30);
        void'(hdr_bytes.pop_back());
        send_header();
        compose_fixdate(15, 5, 2020, 10, 20, 30);
        hdr_bytes.push_back(CH_SPACE);
        send_header();
        compose_fixdate(15, 5, 2020, 10, 20, 30);
        repeat (11) hdr_bytes.push_back(8'($urandom_range(255)));
        send_header();

        // Weekday bytes at the ends of the byte range are still ignored.
        compose_fixdate(28, 1, 2024, 23, 59, 59);
        hdr_bytes[0] = 8'hFF;
        hdr_bytes[1] = 8'h00;
        send_header();

        // Long output hold-off with the input running flat out: the queue
        // fills and the parser has to push back on the header bytes.
        start_phase(0, 0);
        hold_receiver();
        repeat (4) begin
            compose_random_fixdate();
            send_header();
        end

        // Random headers, mostly well formed, the rest damaged or set to a
        // wrong length. Idling changes every two headers, after the
        // sender has waited for every outstanding date.
        rand_headers      = 0;
        first_random_byte = bytes_sent;
        while (bytes_sent - first_random_byte < RANDOM_BYTES ||
               rand_headers < MIN_RANDOM_HEADERS) begin
            if (rand_headers % 2 == 0) begin
                case ((rand_headers / 2) % 4)
                    0:       start_phase(0, 0);
                    1:       start_phase(50, 0);
                    2:       start_phase(0, 50);
                    default: start_phase(20, 20);
                endcase
            end
            kind = $urandom_range(99);
            compose_random_fixdate();
            if (kind >= 75 && kind < 85) begin
                hdr_bytes[$urandom_range(28)] = 8'($urandom_range(255));
            end else if (kind >= 85 && kind < 92) begin
                cut = $urandom_range(28, 1);
                while (hdr_bytes.size() > cut) void'(hdr_bytes.pop_back());
            end else if (kind >= 92) begin
                repeat ($urandom_range(12, 1)) hdr_bytes.push_back(8'($urandom_range(255)));
            end
            send_header();
            rand_headers++;
        end

        wait_drained();

        $display("tb_top: %0d header bytes in %0d headers, %0d dates checked, %0d valid",
                 bytes_sent, headers_sent, dates_seen, dates_valid);
        $display("tb_top: idling off, on the input, on the output and on both, %s",
                 "plus one long output hold-off against a full input");
        if (error_count == 0 && dates_due == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
